[hw/rtl/bta_pkg.sv]
package bta_pkg;

	localparam int MAX_LEVELS_DEF = 10;

	localparam int ORD_W      = 5;
	localparam int SIZE_W     = 31;
	localparam int OFFSET_W   = 30;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int MIN_ORDER_W   = 5;
	localparam int LEVEL_COUNT_W = 4;

	localparam logic [MIN_ORDER_W-1:0]   MIN_ORDER_RST   = 5'd4;
	localparam logic [LEVEL_COUNT_W-1:0] LEVEL_COUNT_RST = 4'd10;
	localparam logic [ORD_W-1:0] MIN_ORDER_LO   = 5'd1;
	localparam logic [ORD_W-1:0] MIN_ORDER_HI   = 5'd20;
	localparam logic [ORD_W-1:0] POOL_ORDER_MAX = 5'd30;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_ORDER   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 1'b1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_ROOM  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

	typedef struct packed {
		logic                command;
		logic [SIZE_W-1:0]   request_size;
		logic [OFFSET_W-1:0] free_offset;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [OFFSET_W-1:0] block_offset;
		logic [ORD_W-1:0]    block_order;
	} result_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_PREP,
		S_ACHECK,
		S_DOWN,
		S_LOOK,
		S_FIND,
		S_UP,
		S_EMIT
	} state_t;

endpackage

[hw/rtl/bta_ram.sv]
module bta_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/buddy_tree_allocator.sv]
// Binary buddy allocator. The tree of largest-free orders lives in one RAM of
// 2^MAX_LEVELS-1 rows, each row holding a sibling pair, with the root in a register;
// every tree level costs one RAM access. Requests are handled one at a time; a finished
// result waits in the output register while the next request is taken. After reset
// and after every register write a clearing pass rewrites each RAM row once, during
// which request_ready stays low. Write the registers only while no request is in flight.
module buddy_tree_allocator #(
	parameter int MAX_LEVELS = bta_pkg::MAX_LEVELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             request_valid,
	output logic                             request_ready,
	input  bta_pkg::request_t                request,
	output logic                             result_valid,
	input  logic                             result_ready,
	output bta_pkg::result_t                 result,
	input  logic                             cfg_we,
	input  logic [bta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bta_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int NW   = MAX_LEVELS + 1;
	localparam int AW   = MAX_LEVELS;
	localparam int ROWS = (1 << MAX_LEVELS) - 1;
	localparam int OW   = bta_pkg::ORD_W;
	localparam int RW   = 2 * OW;
	localparam int FW   = bta_pkg::OFFSET_W;
	localparam int FW1  = bta_pkg::OFFSET_W + 1;
	localparam int SW   = bta_pkg::SIZE_W;

	// node index of the parent, node 0 is the root
	function automatic logic [NW-1:0] parent_of(input logic [NW-1:0] n);
		return (n - NW'(1)) >> 1;
	endfunction

	function automatic logic [FW-1:0] low_mask(input logic [OW-1:0] k);
		logic [FW1-1:0] m;
		m = (FW1'(1) << k) - FW1'(1);
		return m[FW-1:0];
	endfunction

	// bits needed to hold v, by halving the search window
	function automatic logic [OW-1:0] bit_len(input logic [SW-1:0] v);
		logic [31:0]   x;
		logic [OW-1:0] p;
		x = {1'b0, v};
		p = '0;
		if (x[31:16] != '0) begin
			p[4] = 1'b1;
			x = x >> 16;
		end
		if (x[15:8] != '0) begin
			p[3] = 1'b1;
			x = x >> 8;
		end
		if (x[7:4] != '0) begin
			p[2] = 1'b1;
			x = x >> 4;
		end
		if (x[3:2] != '0) begin
			p[1] = 1'b1;
			x = x >> 2;
		end
		if (x[1]) begin
			p[0] = 1'b1;
		end
		return (v == '0) ? '0 : p + OW'(1);
	endfunction

	bta_pkg::state_t state_q, state_d;

	logic [bta_pkg::MIN_ORDER_W-1:0]   min_order_q;
	logic [bta_pkg::LEVEL_COUNT_W-1:0] level_count_q;
	logic [OW-1:0] mo_eff, cap, lv_c, pool;
	logic [bta_pkg::LEVEL_COUNT_W-1:0] lv_eff;

	bta_pkg::request_t req_q, req_d;
	bta_pkg::result_t  res_q, res_d, result_q;
	logic              rv_q, load_result;

	logic [OW-1:0] ord_q, ord_d, cur_q, cur_d, v_q, v_d, root_q, root_d;
	logic [NW-1:0] idx_q, idx_d, n_q, n_d;
	logic [FW-1:0] off_q, off_d;
	logic [AW-1:0] clr_row_q, clr_row_d, clr_last_q, clr_last_d;
	logic [OW-1:0] clr_depth_q, clr_depth_d, depth_p1, clr_val;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [RW-1:0] ram_wdata, ram_rdata;
	logic [OW-1:0] rd_left, rd_right;

	// shared climb step: write a node's new order into its parent's row
	logic [NW-1:0] u_node, up_par, up_gpar;
	logic [OW-1:0] u_val, u_ord, up_l, up_r, up_new;
	logic          up_merge, do_up;

	logic [SW-1:0] size_m1;
	logic [OW-1:0] need;
	logic          go_left;
	logic [NW-1:0] new_idx, leaf;
	logic [FW-1:0] half, off_nx;
	logic [OW-1:0] find_val;
	logic          free_ok, is_free;

	// effective register values
	always_comb begin
		mo_eff = min_order_q;
		if (min_order_q < bta_pkg::MIN_ORDER_LO) begin
			mo_eff = bta_pkg::MIN_ORDER_LO;
		end else if (min_order_q > bta_pkg::MIN_ORDER_HI) begin
			mo_eff = bta_pkg::MIN_ORDER_HI;
		end
		cap = bta_pkg::POOL_ORDER_MAX - mo_eff;
		lv_c = {1'b0, level_count_q};
		if (lv_c < OW'(1)) begin
			lv_c = OW'(1);
		end
		if (lv_c > OW'(MAX_LEVELS)) begin
			lv_c = OW'(MAX_LEVELS);
		end
		if (lv_c > cap) begin
			lv_c = cap;
		end
	end

	assign lv_eff = lv_c[bta_pkg::LEVEL_COUNT_W-1:0];
	assign pool   = mo_eff + {1'b0, lv_eff};

	assign rd_left  = ram_rdata[RW-1:OW];
	assign rd_right = ram_rdata[OW-1:0];

	assign depth_p1 = clr_depth_q + OW'(1);
	assign clr_val  = (depth_p1 <= {1'b0, lv_eff}) ? pool - depth_p1 : '0;

	assign is_free = (req_q.command == bta_pkg::CMD_FREE);
	assign size_m1 = (req_q.request_size == '0) ? '0 : req_q.request_size - SW'(1);
	assign need    = bit_len(size_m1);
	assign free_ok = ((req_q.free_offset & ~low_mask(pool)) == '0) &&
	                 ((req_q.free_offset & low_mask(mo_eff)) == '0);
	assign leaf    = (NW'(1) << lv_eff) - NW'(1) + NW'(req_q.free_offset >> mo_eff);

	assign go_left = (rd_left >= ord_q);
	assign new_idx = (idx_q << 1) + (go_left ? NW'(1) : NW'(2));
	assign half    = FW'(1) << (cur_q - OW'(1));
	assign off_nx  = go_left ? off_q : (off_q | half);

	assign find_val = (n_q == '0) ? root_q : (n_q[0] ? rd_left : rd_right);

	always_comb begin
		case (state_q)
			bta_pkg::S_DOWN: begin
				u_node = new_idx;
				u_val  = '0;
				u_ord  = ord_q;
			end
			bta_pkg::S_FIND: begin
				u_node = n_q;
				u_val  = cur_q;
				u_ord  = cur_q;
			end
			default: begin
				u_node = n_q;
				u_val  = v_q;
				u_ord  = cur_q;
			end
		endcase
	end

	assign up_par  = parent_of(u_node);
	assign up_gpar = parent_of(up_par);
	assign up_l    = u_node[0] ? u_val : rd_left;
	assign up_r    = u_node[0] ? rd_right : u_val;
	// two wholly free buddies join into one block
	assign up_merge = is_free && (up_l == u_ord) && (up_r == u_ord);
	assign up_new   = up_merge ? u_ord + OW'(1) : ((up_l > up_r) ? up_l : up_r);

	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		res_d       = res_q;
		ord_d       = ord_q;
		idx_d       = idx_q;
		cur_d       = cur_q;
		off_d       = off_q;
		n_d         = n_q;
		v_d         = v_q;
		root_d      = root_q;
		clr_row_d   = clr_row_q;
		clr_depth_d = clr_depth_q;
		clr_last_d  = clr_last_q;
		ram_we      = 1'b0;
		ram_waddr   = up_par[AW-1:0];
		ram_wdata   = {up_l, up_r};
		ram_raddr   = up_gpar[AW-1:0];
		load_result = 1'b0;
		request_ready = 1'b0;
		do_up       = 1'b0;
		case (state_q)
			bta_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_row_q;
				ram_wdata = {clr_val, clr_val};
				root_d    = pool;
				clr_row_d = clr_row_q + AW'(1);
				if (clr_row_q == clr_last_q) begin
					clr_depth_d = depth_p1;
					clr_last_d  = (clr_last_q << 1) + AW'(2);
				end
				if (clr_row_q == AW'(ROWS - 1)) begin
					state_d = bta_pkg::S_IDLE;
				end
			end
			bta_pkg::S_IDLE: begin
				request_ready = !cfg_we;
				if (request_valid && !cfg_we) begin
					req_d   = request;
					state_d = bta_pkg::S_PREP;
				end
			end
			bta_pkg::S_PREP: begin
				if (!is_free) begin
					ord_d   = (need > mo_eff) ? need : mo_eff;
					state_d = bta_pkg::S_ACHECK;
				end else if (free_ok) begin
					n_d     = leaf;
					cur_d   = mo_eff;
					state_d = bta_pkg::S_LOOK;
				end else begin
					res_d.status       = bta_pkg::STATUS_BAD_FREE;
					res_d.block_offset = '0;
					res_d.block_order  = '0;
					state_d            = bta_pkg::S_EMIT;
				end
			end
			bta_pkg::S_ACHECK: begin
				res_d.block_offset = '0;
				if (root_q < ord_q) begin
					res_d.status      = bta_pkg::STATUS_NO_ROOM;
					res_d.block_order = '0;
					state_d           = bta_pkg::S_EMIT;
				end else if (ord_q == pool) begin
					// whole pool in one block
					root_d            = '0;
					res_d.status      = bta_pkg::STATUS_OK;
					res_d.block_order = ord_q;
					state_d           = bta_pkg::S_EMIT;
				end else begin
					cur_d     = pool;
					idx_d     = '0;
					off_d     = '0;
					ram_raddr = '0;
					state_d   = bta_pkg::S_DOWN;
				end
			end
			bta_pkg::S_DOWN: begin
				if (cur_q - OW'(1) == ord_q) begin
					ram_we             = 1'b1;
					res_d.status       = bta_pkg::STATUS_OK;
					res_d.block_offset = off_nx;
					res_d.block_order  = ord_q;
					do_up              = 1'b1;
				end else begin
					idx_d     = new_idx;
					cur_d     = cur_q - OW'(1);
					off_d     = off_nx;
					ram_raddr = new_idx[AW-1:0];
				end
			end
			bta_pkg::S_LOOK: begin
				ram_raddr = up_par[AW-1:0];
				state_d   = bta_pkg::S_FIND;
			end
			bta_pkg::S_FIND: begin
				if (find_val == '0) begin
					res_d.status       = bta_pkg::STATUS_OK;
					res_d.block_offset = '0;
					res_d.block_order  = cur_q;
					if (n_q == '0) begin
						root_d  = cur_q;
						state_d = bta_pkg::S_EMIT;
					end else begin
						ram_we = 1'b1;
						do_up  = 1'b1;
					end
				end else if (n_q == '0 || !n_q[0]) begin
					// a right child cannot start a larger block
					res_d.status       = bta_pkg::STATUS_BAD_FREE;
					res_d.block_offset = '0;
					res_d.block_order  = '0;
					state_d            = bta_pkg::S_EMIT;
				end else begin
					n_d   = up_par;
					cur_d = cur_q + OW'(1);
				end
			end
			bta_pkg::S_UP: begin
				ram_we = 1'b1;
				do_up  = 1'b1;
			end
			bta_pkg::S_EMIT: begin
				if (!rv_q || result_ready) begin
					load_result = 1'b1;
					state_d     = bta_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bta_pkg::S_CLEAR;
			end
		endcase
		if (do_up) begin
			if (up_par == '0) begin
				root_d  = up_new;
				state_d = bta_pkg::S_EMIT;
			end else begin
				n_d     = up_par;
				v_d     = up_new;
				cur_d   = u_ord + OW'(1);
				state_d = bta_pkg::S_UP;
			end
		end
		if (cfg_we) begin
			state_d     = bta_pkg::S_CLEAR;
			clr_row_d   = '0;
			clr_depth_d = '0;
			clr_last_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bta_pkg::S_CLEAR;
			clr_row_q   <= '0;
			clr_depth_q <= '0;
			clr_last_q  <= '0;
		end else begin
			state_q     <= state_d;
			clr_row_q   <= clr_row_d;
			clr_depth_q <= clr_depth_d;
			clr_last_q  <= clr_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_order_q   <= bta_pkg::MIN_ORDER_RST;
			level_count_q <= bta_pkg::LEVEL_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bta_pkg::REG_MIN_ORDER: begin
					min_order_q <= cfg_data;
				end
				bta_pkg::REG_LEVEL_COUNT: begin
					level_count_q <= cfg_data[bta_pkg::LEVEL_COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		req_q  <= req_d;
		res_q  <= res_d;
		ord_q  <= ord_d;
		idx_q  <= idx_d;
		cur_q  <= cur_d;
		off_q  <= off_d;
		n_q    <= n_d;
		v_q    <= v_d;
		root_q <= root_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else if (load_result) begin
			rv_q <= 1'b1;
		end else if (result_ready) begin
			rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q <= res_q;
		end
	end

	assign result_valid = rv_q;
	assign result       = result_q;

	bta_ram #(
		.WIDTH  (RW),
		.DEPTH  (ROWS),
		.ADDR_W (AW)
	) u_tree_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

[hw/rtl/bta_checker.sv]
module bta_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             request_ready,
	input logic             result_valid,
	input logic             result_ready,
	input bta_pkg::result_t result,
	input logic             cfg_we
);

	// failed requests carry no block
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != bta_pkg::STATUS_OK |->
		result.block_offset == '0 && result.block_order == '0)
		else $error("failed request reports a block");

	// every block is at least the minimum order, which is never zero
	a_ok_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == bta_pkg::STATUS_OK |-> result.block_order != '0)
		else $error("granted block of order zero");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	// a register write starts the clearing pass
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !request_ready)
		else $error("request taken right after a register write");

endmodule

bind buddy_tree_allocator bta_checker u_bta_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.request_ready (request_ready),
	.result_valid  (result_valid),
	.result_ready  (result_ready),
	.result        (result),
	.cfg_we        (cfg_we)
);

[tb/sv/tb_buddy_tree_allocator.sv]
module tb_buddy_tree_allocator;
	import bta_pkg::*;

	localparam int NODES = (1 << (MAX_LEVELS_DEF + 1)) - 1;

	logic                  clk;
	logic                  arst_n;
	logic                  request_valid;
	logic                  request_ready;
	request_t              request;
	logic                  result_valid;
	logic                  result_ready;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	buddy_tree_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_ready (request_ready),
		.request       (request),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// own copy of the free-order tree and the two registers
	logic [ORD_W-1:0]         free_order [0:NODES-1];
	logic [MIN_ORDER_W-1:0]   min_order_reg;
	logic [LEVEL_COUNT_W-1:0] level_count_reg;

	result_t     alloc_replies [$];
	int unsigned live_blocks [$];
	int          mismatches;
	int          idle_max;
	int          ready_hold_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned clamped_min_order();
		if (min_order_reg < MIN_ORDER_LO) return MIN_ORDER_LO;
		if (min_order_reg > MIN_ORDER_HI) return MIN_ORDER_HI;
		return min_order_reg;
	endfunction

	function automatic int unsigned clamped_levels();
		int unsigned lv;
		int unsigned cap;
		lv = level_count_reg;
		cap = POOL_ORDER_MAX - clamped_min_order();
		if (lv < 1) lv = 1;
		if (lv > MAX_LEVELS_DEF) lv = MAX_LEVELS_DEF;
		if (lv > cap) lv = cap;
		return lv;
	endfunction

	function automatic int unsigned pool_order();
		return clamped_min_order() + clamped_levels();
	endfunction

	function automatic int unsigned node_rd(int unsigned i);
		return (i < NODES) ? free_order[i] : 0;
	endfunction

	function automatic void node_wr(int unsigned i, int unsigned v);
		if (i < NODES) free_order[i] = ORD_W'(v);
	endfunction

	function automatic void free_whole_tree();
		int unsigned pool;
		int unsigned used;
		int unsigned depth;
		pool = pool_order();
		used = (1 << (clamped_levels() + 1)) - 1;
		depth = 0;
		for (int unsigned i = 0; i < NODES; i++) begin
			if (i + 1 >= (2 << depth)) depth++;
			free_order[i] = (i < used) ? ORD_W'(pool - depth) : '0;
		end
		live_blocks.delete();
	endfunction

	function automatic result_t buddy_step(request_t req);
		result_t         r;
		int unsigned     mo;
		int unsigned     pool;
		int unsigned     idx;
		int unsigned     cur;
		int unsigned     order;
		int unsigned     l;
		int unsigned     rr;
		longint unsigned size;
		longint unsigned off;
		bit              found;
		mo = clamped_min_order();
		pool = mo + clamped_levels();
		idx = 0;
		r = '0;
		if (req.command == CMD_ALLOC) begin
			size = req.request_size;
			order = 0;
			while ((64'd1 << order) < size) order++;
			if (order < mo) order = mo;
			if (node_rd(0) < order) begin
				r.status = STATUS_NO_ROOM;
				return r;
			end
			// left child first whenever it can hold the block
			for (cur = pool; cur > order; cur--) begin
				if (node_rd(2 * idx + 1) >= order) idx = 2 * idx + 1;
				else idx = 2 * idx + 2;
			end
			node_wr(idx, 0);
			r.status = STATUS_OK;
			r.block_offset = OFFSET_W'(((longint'(idx) + 1) << order) - (64'd1 << pool));
			r.block_order = ORD_W'(order);
			live_blocks.push_back(r.block_offset);
			while (idx != 0) begin
				idx = (idx - 1) / 2;
				l = node_rd(2 * idx + 1);
				rr = node_rd(2 * idx + 2);
				node_wr(idx, (l > rr) ? l : rr);
			end
		end else begin
			off = req.free_offset;
			found = 1'b0;
			cur = mo;
			if (off < (64'd1 << pool)) begin
				for (cur = mo; cur <= pool; cur++) begin
					if ((off & ((64'd1 << cur) - 1)) != 0) break;
					idx = ((1 << (pool - cur)) - 1) + int'(off >> cur);
					if (node_rd(idx) == 0) begin
						found = 1'b1;
						break;
					end
				end
			end
			if (!found) begin
				r.status = STATUS_BAD_FREE;
				return r;
			end
			node_wr(idx, cur);
			r.status = STATUS_OK;
			r.block_order = ORD_W'(cur);
			for (int j = 0; j < live_blocks.size(); j++) begin
				if (live_blocks[j] == off) begin
					live_blocks.delete(j);
					break;
				end
			end
			// merge buddies that are both wholly free
			while (idx != 0) begin
				idx = (idx - 1) / 2;
				cur++;
				l = node_rd(2 * idx + 1);
				rr = node_rd(2 * idx + 2);
				if (l == cur - 1 && rr == cur - 1) node_wr(idx, cur);
				else node_wr(idx, (l > rr) ? l : rr);
			end
		end
		return r;
	endfunction

	function automatic request_t make_alloc(int unsigned size);
		request_t q;
		q.command = CMD_ALLOC;
		q.request_size = SIZE_W'(size);
		q.free_offset = OFFSET_W'($urandom);
		return q;
	endfunction

	function automatic request_t make_free(int unsigned off);
		request_t q;
		q.command = CMD_FREE;
		q.request_size = SIZE_W'($urandom_range(0, 32'h4000_0000));
		q.free_offset = OFFSET_W'(off);
		return q;
	endfunction

	// valid stays high after acceptance; the next request or drain_replies decides
	task automatic send_request(request_t item);
		int gap;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			request_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request <= item;
		request_valid <= 1'b1;
		do @(posedge clk); while (!request_ready);
		alloc_replies.push_back(buddy_step(item));
		@(negedge clk);
	endtask

	task automatic drain_replies();
		request_valid <= 1'b0;
		while (alloc_replies.size() != 0) @(negedge clk);
		repeat (2 * MAX_LEVELS_DEF + 12) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MIN_ORDER) min_order_reg = data;
		else level_count_reg = data[LEVEL_COUNT_W-1:0];
		free_whole_tree();
		@(negedge clk);
	endtask

	task automatic set_pool(int unsigned mo, int unsigned levels);
		drain_replies();
		write_reg(REG_MIN_ORDER, CFG_DATA_W'(mo));
		write_reg(REG_LEVEL_COUNT, CFG_DATA_W'(levels));
	endtask

	task automatic run_traffic(int n);
		int unsigned pick;
		int unsigned k;
		int unsigned off;
		int unsigned sh;
		int unsigned mo;
		int unsigned pool;
		for (int i = 0; i < n; i++) begin
			mo = clamped_min_order();
			pool = pool_order();
			pick = $urandom_range(0, 99);
			if (pick < 42 && live_blocks.size() > 0) begin
				k = $urandom_range(0, live_blocks.size() - 1);
				send_request(make_free(live_blocks[k]));
			end else if (pick < 52) begin
				// broken frees: outside, misaligned, or not the start of a live block
				case ($urandom_range(0, 3))
					0: off = $urandom;
					1: off = $urandom_range(0, (1 << pool) - 1);
					2: begin
						if (live_blocks.size() > 0) begin
							k = $urandom_range(0, live_blocks.size() - 1);
							off = live_blocks[k] + (1 << $urandom_range(0, mo - 1));
						end else begin
							off = $urandom_range(0, (1 << pool) - 1);
						end
					end
					default: off = ($urandom_range(0, (1 << pool) - 1) >> mo) << mo;
				endcase
				send_request(make_free(off));
			end else begin
				if ($urandom_range(0, 19) == 0) begin
					send_request(make_alloc($urandom_range(0, 32'h4000_0000)));
				end else begin
					sh = $urandom_range(0, 1) ? $urandom_range(0, mo + 1) : $urandom_range(0, pool);
					send_request(make_alloc($urandom_range(0, 32'd1 << sh)));
				end
			end
		end
	endtask

	task automatic test_directed();
		int unsigned offs [$];
		send_request(make_alloc(0));
		send_request(make_alloc(1));
		send_request(make_alloc(16));
		send_request(make_alloc(17));
		send_request(make_alloc(32'h4000_0000));
		send_request(make_alloc(1 << pool_order()));
		send_request(make_alloc(1 << (pool_order() - 1)));
		send_request(make_free(8));
		send_request(make_free(1 << pool_order()));
		send_request(make_free(30'h3FFF_FFFF));
		send_request(make_free(48));
		send_request(make_free(0));
		send_request(make_free(0));
		offs = live_blocks;
		foreach (offs[i]) send_request(make_free(offs[i]));
		send_request(make_alloc(1 << pool_order()));
		send_request(make_alloc(0));
		send_request(make_free(0));
		send_request(make_free(0));
	endtask

	task automatic test_config_extremes();
		int unsigned mos [9] = '{1, 20, 20, 1, 0, 31, 25, 2, 10};
		int unsigned lvs [9] = '{1, 1, 10, 10, 0, 15, 3, 19, 9};
		for (int s = 0; s < 9; s++) begin
			set_pool(mos[s], lvs[s]);
			send_request(make_alloc(1 << pool_order()));
			send_request(make_alloc(0));
			send_request(make_free(0));
			run_traffic(30);
		end
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 6; p++) begin
			set_pool($urandom_range(1, 8), $urandom_range(1, 10));
			// one phase with no idling on either side
			idle_max = (p == 3) ? 0 : 10;
			run_traffic(250);
		end
		idle_max = 10;
	endtask

	task automatic test_output_backpressure();
		set_pool(3, 6);
		ready_hold_cycles = 400;
		run_traffic(40);
	endtask

	task automatic check_reply(result_t got);
		result_t want;
		if (alloc_replies.size() == 0) begin
			$display("%0t: reply with nothing pending, actual status %0d offset %0h order %0d",
				$time, got.status, got.block_offset, got.block_order);
			mismatches++;
			return;
		end
		want = alloc_replies.pop_front();
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			mismatches++;
		end
		if (got.block_offset !== want.block_offset) begin
			$display("%0t: block_offset expected %0h actual %0h",
				$time, want.block_offset, got.block_offset);
			mismatches++;
		end
		if (got.block_order !== want.block_order) begin
			$display("%0t: block_order expected %0d actual %0d",
				$time, want.block_order, got.block_order);
			mismatches++;
		end
	endtask

	// reply side: random stalls, and a long hold-off when one is asked for
	initial begin
		int gap;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (ready_hold_cycles > 0) begin
				gap = ready_hold_cycles;
				ready_hold_cycles = 0;
			end else begin
				gap = $urandom_range(0, idle_max);
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			check_reply(result);
			@(negedge clk);
		end
	end

	initial begin
		#1500000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		request_valid = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		idle_max = 10;
		ready_hold_cycles = 0;
		min_order_reg = MIN_ORDER_RST;
		level_count_reg = LEVEL_COUNT_RST;
		free_whole_tree();
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_config_extremes();
		test_random_traffic();
		test_output_backpressure();
		drain_replies();
		if (mismatches == 0 && alloc_replies.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/bta_pkg.sv
hw/rtl/bta_ram.sv
hw/rtl/buddy_tree_allocator.sv
hw/rtl/bta_checker.sv
tb/sv/tb_buddy_tree_allocator.sv
